[hw/rtl/gdsrd_pkg.sv]
// Shared types, codes and helpers for the GDSII record deframer.
// Used by every module of the block; depends on nothing else.
package gdsrd_pkg;

    // Result kinds carried in the low bits of tuser.
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    // GDSII data type codes.
    localparam logic [7:0] DT_BITS  = 8'd1;
    localparam logic [7:0] DT_INT16 = 8'd2;
    localparam logic [7:0] DT_INT32 = 8'd3;
    localparam logic [7:0] DT_REAL4 = 8'd4;
    localparam logic [7:0] DT_REAL8 = 8'd5;
    localparam logic [7:0] DT_ASCII = 8'd6;

    // Record type code of ENDLIB.
    localparam logic [7:0] REC_ENDLIB = 8'd4;

    // Smallest legal record length (the header alone).
    localparam logic [15:0] MIN_REC_LEN = 16'd4;

    // Biased double exponent is lead + 4*e + this offset (1023 - 256 - 56).
    localparam logic [11:0] EXP_OFFSET = 12'd711;

    // Default depth of the queue between front and back.
    localparam int unsigned FIFO_DEPTH_DEF = 4;

    // Output bus layout.
    localparam int unsigned M_TDATA_W = 112;
    localparam int unsigned M_TUSER_W = 4;
    localparam int unsigned INDEX_LSB = 32;
    localparam int unsigned VALUE_LSB = 47;
    localparam int unsigned VALUE_MSB = 110;

    // One classified result as handed from front to back.
    typedef struct packed {
        kind_t        kind;
        logic [7:0]   record_type;
        logic [7:0]   data_type;
        logic [15:0]  record_length;
        logic [14:0]  element_index;
        logic [63:0]  raw;
        logic         last;
        logic         pad;
        logic         eol;
    } gdsrd_entry_t;

    // Bytes per element for a data type; zero for types without elements.
    function automatic logic [3:0] elem_size(input logic [7:0] dt);
        logic [3:0] size;
        case (dt)
            DT_BITS:  size = 4'd2;
            DT_INT16: size = 4'd2;
            DT_INT32: size = 4'd4;
            DT_REAL4: size = 4'd4;
            DT_REAL8: size = 4'd8;
            DT_ASCII: size = 4'd1;
            default:  size = 4'd0;
        endcase
        return size;
    endfunction

endpackage

[hw/rtl/gdsrd_front.sv]
// Front part of the GDSII record deframer: frames records from the byte
// stream and classifies each header, error and data element. Uses gdsrd_pkg.
module gdsrd_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    input  logic [7:0]             byte_data,
    output logic                   push,
    output gdsrd_pkg::gdsrd_entry_t push_entry
);
    import gdsrd_pkg::*;

    logic [1:0]  hdr_pos_reg, hdr_pos_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  rtype_reg, rtype_next;
    logic [7:0]  dtype_reg, dtype_next;
    logic [15:0] rem_reg, rem_next;
    logic [63:0] asm_reg, asm_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [14:0] idx_reg, idx_next;
    logic        done_reg, done_next;

    logic [15:0] rem_dec;
    logic        rec_last;
    logic [3:0]  size;
    logic [63:0] asm_shift;

    assign rem_dec   = rem_reg - 16'd1;
    assign rec_last  = (rem_dec == 16'd0);
    assign size      = elem_size(dtype_reg);
    assign asm_shift = {asm_reg[55:0], byte_data};

    // Framing: header bytes, then data bytes grouped into elements.
    always_comb
    begin
        hdr_pos_next = hdr_pos_reg;
        len_next     = len_reg;
        rtype_next   = rtype_reg;
        dtype_next   = dtype_reg;
        rem_next     = rem_reg;
        asm_next     = asm_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        done_next    = done_reg;
        push         = 1'b0;
        push_entry   = '0;
        push_entry.record_type   = rtype_reg;
        push_entry.data_type     = dtype_reg;
        push_entry.record_length = len_reg;

        if (byte_valid && !done_reg)
        begin
            if (rem_reg == 16'd0)
            begin
                // Header byte.
                case (hdr_pos_reg)
                    2'd0:    len_next   = {byte_data, 8'h00};
                    2'd1:    len_next   = {len_reg[15:8], byte_data};
                    2'd2:    rtype_next = byte_data;
                    default: dtype_next = byte_data;
                endcase
                if (hdr_pos_reg != 2'd3)
                begin
                    hdr_pos_next = hdr_pos_reg + 2'd1;
                end
                else
                begin
                    hdr_pos_next = 2'd0;
                    asm_next     = '0;
                    cnt_next     = '0;
                    idx_next     = '0;
                    push         = 1'b1;
                    push_entry.data_type = byte_data;
                    if (len_reg < MIN_REC_LEN)
                    begin
                        push_entry.kind = KIND_ERROR;
                        push_entry.last = 1'b1;
                    end
                    else
                    begin
                        rem_next        = len_reg - MIN_REC_LEN;
                        push_entry.kind = KIND_HEADER;
                        push_entry.last = (len_reg == MIN_REC_LEN);
                        push_entry.eol  = (rtype_reg == REC_ENDLIB);
                        if (len_reg == MIN_REC_LEN && rtype_reg == REC_ENDLIB)
                        begin
                            done_next = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                // Data byte.
                rem_next = rem_dec;
                if (size != 4'd0)
                begin
                    if (({1'b0, cnt_reg} + 4'd1) == size)
                    begin
                        push                     = 1'b1;
                        push_entry.kind          = KIND_DATA;
                        push_entry.element_index = idx_reg;
                        push_entry.raw           = asm_shift;
                        push_entry.last          = rec_last;
                        push_entry.pad = (dtype_reg == DT_ASCII) && (byte_data == 8'd0)
                                         && rec_last;
                        idx_next = idx_reg + 15'd1;
                        cnt_next = '0;
                        asm_next = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                        asm_next = asm_shift;
                    end
                end
                if (rec_last)
                begin
                    cnt_next = '0;
                    asm_next = '0;
                    if (rtype_reg == REC_ENDLIB)
                    begin
                        done_next = 1'b1;
                    end
                end
            end
        end
    end

    // Framing state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg <= '0;
            len_reg     <= '0;
            rtype_reg   <= '0;
            dtype_reg   <= '0;
            rem_reg     <= '0;
            asm_reg     <= '0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            hdr_pos_reg <= hdr_pos_next;
            len_reg     <= len_next;
            rtype_reg   <= rtype_next;
            dtype_reg   <= dtype_next;
            rem_reg     <= rem_next;
            asm_reg     <= asm_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            done_reg    <= done_next;
        end
    end

endmodule

[hw/rtl/gdsrd_fifo.sv]
// Short queue between the front and back parts of the deframer.
// Holds classified entries; uses gdsrd_pkg for the entry type.
module gdsrd_fifo #(
    parameter int unsigned DEPTH = gdsrd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  gdsrd_pkg::gdsrd_entry_t push_entry,
    output logic                    full,
    input  logic                    pop,
    output gdsrd_pkg::gdsrd_entry_t pop_entry,
    output logic                    not_empty
);
    import gdsrd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    gdsrd_entry_t     slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; no reset needed for payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[hw/rtl/gdsrd_back.sv]
// Back part of the deframer: decodes element values (integer sign
// extension, hex real to double) and drives the output stream. Uses gdsrd_pkg.
module gdsrd_back (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    fifo_not_empty,
    input  gdsrd_pkg::gdsrd_entry_t                 fifo_entry,
    output logic                                    pop,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [gdsrd_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    output logic [gdsrd_pkg::M_TUSER_W-1:0]         m_axis_tuser,
    output logic                                    m_axis_tlast
);
    import gdsrd_pkg::*;

    logic         advance;
    logic [55:0]  in_mant;
    logic [5:0]   in_lead;

    logic         s1_valid_reg;
    gdsrd_entry_t s1_entry_reg;
    logic [5:0]   s1_lead_reg;

    logic         out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TUSER_W-1:0] out_user_reg;
    logic         out_last_reg;

    logic         r_sign;
    logic [6:0]   r_exp;
    logic [55:0]  r_mant;
    logic [55:0]  r_norm;
    logic         r_up;
    logic [53:0]  r_sum;
    logic [11:0]  r_expo;
    logic [63:0]  real_bits;
    logic [63:0]  value;

    // The pipeline moves whenever the output register is free or drains.
    assign advance = !out_valid_reg || m_axis_tready;
    assign pop     = advance && fifo_not_empty;

    // Stage one: find the leading one of the hex real mantissa.
    always_comb
    begin
        in_mant = (fifo_entry.data_type == DT_REAL4) ?
                  {fifo_entry.raw[23:0], 32'd0} : fifo_entry.raw[55:0];
        in_lead = '0;
        for (int i = 0; i < 56; i++)
        begin
            if (in_mant[i])
            begin
                in_lead = 6'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= fifo_not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_entry_reg <= fifo_entry;
            s1_lead_reg  <= in_lead;
        end
    end

    // Stage two: normalize, round to nearest even and build the double.
    always_comb
    begin
        if (s1_entry_reg.data_type == DT_REAL4)
        begin
            r_sign = s1_entry_reg.raw[31];
            r_exp  = s1_entry_reg.raw[30:24];
            r_mant = {s1_entry_reg.raw[23:0], 32'd0};
        end
        else
        begin
            r_sign = s1_entry_reg.raw[63];
            r_exp  = s1_entry_reg.raw[62:56];
            r_mant = s1_entry_reg.raw[55:0];
        end
        r_norm = r_mant << (6'd55 - s1_lead_reg);
        r_up   = r_norm[2] && (r_norm[3] || r_norm[1] || r_norm[0]);
        r_sum  = {1'b0, r_norm[55:3]} + 54'(r_up);
        r_expo = 12'(s1_lead_reg) + {3'd0, r_exp, 2'd0} + EXP_OFFSET + 12'(r_sum[53]);
        if (r_mant == 56'd0)
        begin
            real_bits = {r_sign, 63'd0};
        end
        else
        begin
            real_bits = {r_sign, r_expo[10:0], r_sum[51:0]};
        end
    end

    // Element value by data type; header and error results carry zero.
    always_comb
    begin
        value = '0;
        if (s1_entry_reg.kind == KIND_DATA)
        begin
            case (s1_entry_reg.data_type)
                DT_BITS:  value = {48'd0, s1_entry_reg.raw[15:0]};
                DT_INT16: value = {{48{s1_entry_reg.raw[15]}}, s1_entry_reg.raw[15:0]};
                DT_INT32: value = {{32{s1_entry_reg.raw[31]}}, s1_entry_reg.raw[31:0]};
                DT_REAL4: value = real_bits;
                DT_REAL8: value = real_bits;
                DT_ASCII: value = {56'd0, s1_entry_reg.raw[7:0]};
                default:  value = '0;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {1'b0, value, s1_entry_reg.element_index,
                             s1_entry_reg.record_length, s1_entry_reg.data_type,
                             s1_entry_reg.record_type};
            out_user_reg <= {s1_entry_reg.eol, s1_entry_reg.pad, s1_entry_reg.kind};
            out_last_reg <= s1_entry_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

[hw/rtl/gdsii_record_deframer_unit.sv]
// GDSII record deframer: one byte per cycle in while the queue has room, one
// result beat per record header, length error or complete data element out.
// A result passes through the queue, then the stage-one and output registers.
// Throughput: one byte per cycle, set by the framing loop; a full queue stalls.
// Reset: all framing state cleared, the queue and pipeline emptied; the
// next byte is taken as the first header byte. No clearing pass.
module gdsii_record_deframer_unit #(
    parameter int unsigned FIFO_DEPTH = gdsrd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] stream_byte
    input  logic [7:0]                       s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] record_type, [15:8] data_type, [31:16] record_length,
    // [46:32] element_index, [110:47] element_value, [111] zero
    output logic [gdsrd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [1:0] kind, [2] pad_byte, [3] end_of_library
    output logic [gdsrd_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    // last_in_record
    output logic                             m_axis_tlast
);
    import gdsrd_pkg::*;

    logic         byte_valid;
    logic         push;
    gdsrd_entry_t push_entry;
    logic         fifo_full;
    logic         pop;
    gdsrd_entry_t pop_entry;
    logic         fifo_not_empty;

    // A byte is taken whenever the queue has room for its possible result.
    assign s_axis_tready = !fifo_full;
    assign byte_valid    = s_axis_tvalid && s_axis_tready;

    gdsrd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (s_axis_tdata),
        .push       (push),
        .push_entry (push_entry)
    );

    gdsrd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (fifo_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .not_empty  (fifo_not_empty)
    );

    gdsrd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .fifo_not_empty (fifo_not_empty),
        .fifo_entry     (pop_entry),
        .pop            (pop),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast)
    );

    // Header and error beats carry a zero element index and value.
    a_hdr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1:0] != KIND_DATA)
        |-> (m_axis_tdata[VALUE_MSB:INDEX_LSB] == '0))
        else $error("header or error beat with nonzero index or value");

    // A length error always closes its record.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1:0] == KIND_ERROR) |-> m_axis_tlast)
        else $error("length error beat without tlast");

    // Padding is only a final zero string byte.
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2])
        |-> (m_axis_tlast && m_axis_tuser[1:0] == KIND_DATA
             && m_axis_tdata[15:8] == DT_ASCII
             && m_axis_tdata[VALUE_MSB:VALUE_LSB] == '0))
        else $error("pad flag on a beat that is not a final zero string byte");

endmodule
